[design/nonl_pkg.sv]
// shared types and constants of the noisy or/nor likelihood block
`default_nettype none

package nonl_pkg;

    // register indexes on the configuration port
    localparam int unsigned REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_NOISE_NOT_ONE = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_NOISE_ONE     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PRIOR_ZERO    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PRIOR_ONE     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PRIOR_TWO     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_NODE_STATE    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_DATA_IS_ONE   = 3'd6;

    // parent sign codes
    localparam logic [1:0] SIGN_ZERO    = 2'd0;
    localparam logic [1:0] SIGN_IGNORED = 2'd1;
    localparam logic [1:0] SIGN_TWO     = 2'd2;

    // node state codes
    localparam logic [1:0] NODE_ZERO = 2'd0;
    localparam logic [1:0] NODE_ONE  = 2'd1;
    localparam logic [1:0] NODE_TWO  = 2'd2;
    localparam logic [1:0] NODE_BAD  = 2'd3;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROD,
        ST_ACC,
        ST_FIN_M1,
        ST_FIN_M2,
        ST_FIN_M3,
        ST_EMIT
    } ctrl_state_t;

    // operation of the shared multiplier
    typedef enum logic [2:0] {
        OP_ZC,
        OP_P,
        OP_ACC,
        OP_M1,
        OP_M2,
        OP_M3
    } mul_op_t;

    // controller to datapath
    typedef struct packed {
        logic    accept;
        mul_op_t op;
        logic    emit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_prod;
        logic last_now;
        logic last_held;
        logic bad_state;
        logic state_two;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

[design/nonl_ifs.sv]
// valid/ready channel interfaces for parent items and likelihood results
`default_nettype none

interface nonl_in_if #(
    parameter int FRAC_BITS = 16
);
    localparam int Q_W = FRAC_BITS + 1;

    logic           valid;
    logic           ready;
    logic [Q_W-1:0] parent_act_prob;
    logic           parent_present;
    logic [1:0]     parent_sign;
    logic           last_parent;

    modport source (output valid, parent_act_prob, parent_present, parent_sign, last_parent,
                    input ready);
    modport sink   (input valid, parent_act_prob, parent_present, parent_sign, last_parent,
                    output ready);
endinterface

interface nonl_out_if #(
    parameter int FRAC_BITS = 16
);
    localparam int Q_W = FRAC_BITS + 1;

    logic           valid;
    logic           ready;
    logic [Q_W-1:0] likelihood;
    logic           state_error;

    modport source (output valid, likelihood, state_error, input ready);
    modport sink   (input valid, likelihood, state_error, output ready);
endinterface

`default_nettype wire

[design/nonl_cfg.sv]
// configuration register file behind the apb-style port
`default_nettype none

module nonl_cfg #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic psel,
    input  wire logic penable,
    input  wire logic pwrite,
    input  wire logic [((FRAC_BITS + 1 > 32) ? 3 : 2) + nonl_pkg::REG_IDX_W - 1:0] paddr,
    input  wire logic [((FRAC_BITS + 1 > 32) ? 64 : 32) - 1:0] pwdata,
    output logic pready,
    output logic [((FRAC_BITS + 1 > 32) ? 64 : 32) - 1:0] prdata,
    output logic [FRAC_BITS:0] noise_not_one,
    output logic [FRAC_BITS:0] noise_one,
    output logic [FRAC_BITS:0] prior_zero,
    output logic [FRAC_BITS:0] prior_one,
    output logic [FRAC_BITS:0] prior_two,
    output logic [1:0] node_state,
    output logic data_is_one
);
    import nonl_pkg::*;

    localparam int Q_W      = FRAC_BITS + 1;
    localparam int DATA_W   = (Q_W > 32) ? 64 : 32;
    localparam int STRIDE_W = (Q_W > 32) ? 3 : 2;
    localparam int ADDR_W   = STRIDE_W + REG_IDX_W;
    localparam logic [Q_W-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

    logic [Q_W-1:0]       noise_not_one_reg, noise_one_reg;
    logic [Q_W-1:0]       prior_zero_reg, prior_one_reg, prior_two_reg;
    logic [1:0]           node_state_reg;
    logic                 data_is_one_reg;
    logic [REG_IDX_W-1:0] idx;
    logic [Q_W-1:0]       wq;
    logic                 wr;

    // decode and clamp the written value to one
    assign idx = paddr[ADDR_W-1:STRIDE_W];
    assign wr  = psel && penable && pwrite;
    assign wq  = (pwdata[Q_W-1:0] > ONE_Q) ? ONE_Q : pwdata[Q_W-1:0];
    assign pready = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_not_one_reg <= '0;
            noise_one_reg     <= '0;
            prior_zero_reg    <= '0;
            prior_one_reg     <= '0;
            prior_two_reg     <= '0;
            node_state_reg    <= NODE_ZERO;
            data_is_one_reg   <= 1'b0;
        end
        else if (wr)
        begin
            case (idx)
                REG_NOISE_NOT_ONE: noise_not_one_reg <= wq;
                REG_NOISE_ONE:     noise_one_reg     <= wq;
                REG_PRIOR_ZERO:    prior_zero_reg    <= wq;
                REG_PRIOR_ONE:     prior_one_reg     <= wq;
                REG_PRIOR_TWO:     prior_two_reg     <= wq;
                REG_NODE_STATE:    node_state_reg    <= pwdata[1:0];
                REG_DATA_IS_ONE:   data_is_one_reg   <= pwdata[0];
                default:           ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        prdata = '0;
        case (idx)
            REG_NOISE_NOT_ONE: prdata = DATA_W'(noise_not_one_reg);
            REG_NOISE_ONE:     prdata = DATA_W'(noise_one_reg);
            REG_PRIOR_ZERO:    prdata = DATA_W'(prior_zero_reg);
            REG_PRIOR_ONE:     prdata = DATA_W'(prior_one_reg);
            REG_PRIOR_TWO:     prdata = DATA_W'(prior_two_reg);
            REG_NODE_STATE:    prdata = DATA_W'(node_state_reg);
            REG_DATA_IS_ONE:   prdata = DATA_W'(data_is_one_reg);
            default:           prdata = '0;
        endcase
    end

    assign noise_not_one = noise_not_one_reg;
    assign noise_one     = noise_one_reg;
    assign prior_zero    = prior_zero_reg;
    assign prior_one     = prior_one_reg;
    assign prior_two     = prior_two_reg;
    assign node_state    = node_state_reg;
    assign data_is_one   = data_is_one_reg;

endmodule

`default_nettype wire

[design/nonl_ctrl.sv]
// controller state machine sequencing the shared multiplier
`default_nettype none

module nonl_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire nonl_pkg::dp_status_t status,
    output nonl_pkg::dp_cmd_t         cmd
);
    import nonl_pkg::*;

    ctrl_state_t state_reg, state_next;
    ctrl_state_t fin_start;

    // state two needs the extra sign-two by main product first
    assign fin_start = status.state_two ? ST_FIN_M1 : ST_FIN_M2;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd.accept = 1'b0;
        cmd.op     = OP_ZC;
        cmd.emit   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                cmd.op     = OP_ZC;
                if (in_valid)
                begin
                    if (status.bad_state)
                    begin
                        state_next = status.last_now ? ST_EMIT : ST_IDLE;
                    end
                    else if (status.need_prod)
                    begin
                        state_next = ST_PROD;
                    end
                    else if (status.last_now)
                    begin
                        state_next = fin_start;
                    end
                end
            end
            ST_PROD:
            begin
                cmd.op     = OP_P;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.op     = OP_ACC;
                state_next = status.last_held ? fin_start : ST_IDLE;
            end
            ST_FIN_M1:
            begin
                cmd.op     = OP_M1;
                state_next = ST_FIN_M2;
            end
            ST_FIN_M2:
            begin
                cmd.op     = OP_M2;
                state_next = ST_FIN_M3;
            end
            ST_FIN_M3:
            begin
                cmd.op     = OP_M3;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit = status.out_free;
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[design/nonl_dp.sv]
// datapath: running products, shared multiplier and output register
`default_nettype none

module nonl_dp #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire nonl_pkg::dp_cmd_t    cmd,
    output nonl_pkg::dp_status_t      status,
    input  wire logic [FRAC_BITS:0]   parent_act_prob,
    input  wire logic                 parent_present,
    input  wire logic [1:0]           parent_sign,
    input  wire logic                 last_parent,
    input  wire logic [FRAC_BITS:0]   noise_not_one,
    input  wire logic [FRAC_BITS:0]   noise_one,
    input  wire logic [FRAC_BITS:0]   prior_zero,
    input  wire logic [FRAC_BITS:0]   prior_one,
    input  wire logic [FRAC_BITS:0]   prior_two,
    input  wire logic [1:0]           node_state,
    input  wire logic                 data_is_one,
    input  wire logic                 out_ready,
    output logic                      out_valid,
    output logic [FRAC_BITS:0]        likelihood,
    output logic                      state_error
);
    import nonl_pkg::*;

    localparam int Q_W = FRAC_BITS + 1;
    localparam logic [Q_W-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

    logic [Q_W-1:0]   zc_reg, main_reg, two_reg;
    logic [Q_W-1:0]   p_reg, tmp_reg, t_reg;
    logic             last_reg, to_two_reg;
    logic             out_valid_reg, err_reg;
    logic [Q_W-1:0]   lik_reg;
    logic [Q_W-1:0]   z, t_sat, acc_src, m2_a, prior_sel;
    logic [Q_W-1:0]   mul_a, mul_b, mul_q, lik_sum;
    logic [2*Q_W-1:0] mul_full;
    logic [Q_W:0]     sum_wide;
    logic             bad, counted, out_free;

    // per-parent decisions from the live input
    assign z       = data_is_one ? noise_one : noise_not_one;
    assign t_sat   = (parent_act_prob > ONE_Q) ? ONE_Q : parent_act_prob;
    assign bad     = (node_state == NODE_BAD);
    assign counted = (parent_sign != SIGN_IGNORED);
    assign out_free = !out_valid_reg || out_ready;

    assign status.need_prod = counted && parent_present
                              && ((node_state != NODE_ZERO) || (parent_sign == SIGN_ZERO));
    assign status.last_now  = last_parent;
    assign status.last_held = last_reg;
    assign status.bad_state = bad;
    assign status.state_two = (node_state == NODE_TWO);
    assign status.out_free  = out_free;

    // operand selection for the shared multiplier
    assign acc_src = to_two_reg ? two_reg : main_reg;

    always_comb
    begin
        case (node_state)
            NODE_ZERO: m2_a = ONE_Q - main_reg;
            NODE_ONE:  m2_a = main_reg;
            default:   m2_a = main_reg - p_reg;
        endcase
        case (node_state)
            NODE_ZERO: prior_sel = prior_zero;
            NODE_ONE:  prior_sel = prior_one;
            default:   prior_sel = prior_two;
        endcase
    end

    always_comb
    begin
        case (cmd.op)
            OP_ZC:
            begin
                mul_a = zc_reg;
                mul_b = ONE_Q - z;
            end
            OP_P:
            begin
                mul_a = ONE_Q - t_reg;
                mul_b = z;
            end
            OP_ACC:
            begin
                mul_a = acc_src;
                mul_b = p_reg;
            end
            OP_M1:
            begin
                mul_a = two_reg;
                mul_b = main_reg;
            end
            OP_M2:
            begin
                mul_a = m2_a;
                mul_b = ONE_Q - zc_reg;
            end
            OP_M3:
            begin
                mul_a = zc_reg;
                mul_b = prior_sel;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // truncating fixed-point product
    assign mul_full = mul_a * mul_b;
    assign mul_q    = mul_full[FRAC_BITS +: Q_W];

    // final sum, saturated at one
    assign sum_wide = {1'b0, p_reg} + {1'b0, tmp_reg};
    assign lik_sum  = (sum_wide > {1'b0, ONE_Q}) ? ONE_Q : sum_wide[Q_W-1:0];

    // running products and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zc_reg        <= ONE_Q;
            main_reg      <= ONE_Q;
            two_reg       <= ONE_Q;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
            begin
                zc_reg   <= ONE_Q;
                main_reg <= ONE_Q;
                two_reg  <= ONE_Q;
            end
            else if (cmd.accept && !bad && counted)
            begin
                zc_reg <= mul_q;
            end
            else if (cmd.op == OP_ACC)
            begin
                if (to_two_reg)
                begin
                    two_reg <= mul_q;
                end
                else
                begin
                    main_reg <= mul_q;
                end
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // captured inputs, temporaries and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            t_reg      <= t_sat;
            last_reg   <= last_parent;
            to_two_reg <= (node_state == NODE_TWO) && (parent_sign == SIGN_TWO);
        end
        if (cmd.op == OP_P || cmd.op == OP_M1 || cmd.op == OP_M2)
        begin
            p_reg <= mul_q;
        end
        if (cmd.op == OP_M3)
        begin
            tmp_reg <= mul_q;
        end
        if (cmd.emit)
        begin
            lik_reg <= bad ? '0 : lik_sum;
            err_reg <= bad;
        end
    end

    assign out_valid   = out_valid_reg;
    assign likelihood  = lik_reg;
    assign state_error = err_reg;

endmodule

`default_nettype wire

[design/noisy_or_nor_likelihood.sv]
// top level of the noisy or/nor likelihood block
//
//  channel   direction  handshake          payload
//  parent    in         valid/ready        parent_act_prob, parent_present, parent_sign,
//                                          last_parent
//  result    out        valid/ready        likelihood, state_error
//  apb       in         psel/penable       paddr, pwdata, prdata (pready tied high)
//
// a parent that enters a product passes accept with noise update, term and accumulate;
// any other parent is done at accept, all on the one shared multiplier
// the last parent adds multiplies m2 and m3 (m1 too in state two, none if invalid), then emit
// reset sets the products to one and the registers to zero; no clearing pass
// a waiting result sits in the output register; the next node's parents are taken
// meanwhile and only its own final output cycle waits for the slot
`default_nettype none

module noisy_or_nor_likelihood #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    nonl_in_if.sink   parent,
    nonl_out_if.source result,
    input  wire logic psel,
    input  wire logic penable,
    input  wire logic pwrite,
    input  wire logic [((FRAC_BITS + 1 > 32) ? 3 : 2) + nonl_pkg::REG_IDX_W - 1:0] paddr,
    input  wire logic [((FRAC_BITS + 1 > 32) ? 64 : 32) - 1:0] pwdata,
    output logic pready,
    output logic [((FRAC_BITS + 1 > 32) ? 64 : 32) - 1:0] prdata
);
    import nonl_pkg::*;

    logic [FRAC_BITS:0] noise_not_one, noise_one;
    logic [FRAC_BITS:0] prior_zero, prior_one, prior_two;
    logic [1:0]         node_state;
    logic               data_is_one;
    dp_cmd_t            cmd;
    dp_status_t         status;

    // configuration registers
    nonl_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .prdata        (prdata),
        .noise_not_one (noise_not_one),
        .noise_one     (noise_one),
        .prior_zero    (prior_zero),
        .prior_one     (prior_one),
        .prior_two     (prior_two),
        .node_state    (node_state),
        .data_is_one   (data_is_one)
    );

    // sequencing
    nonl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (parent.valid),
        .in_ready (parent.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic
    nonl_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .parent_act_prob (parent.parent_act_prob),
        .parent_present  (parent.parent_present),
        .parent_sign     (parent.parent_sign),
        .last_parent     (parent.last_parent),
        .noise_not_one   (noise_not_one),
        .noise_one       (noise_one),
        .prior_zero      (prior_zero),
        .prior_one       (prior_one),
        .prior_two       (prior_two),
        .node_state      (node_state),
        .data_is_one     (data_is_one),
        .out_ready       (result.ready),
        .out_valid       (result.valid),
        .likelihood      (result.likelihood),
        .state_error     (result.state_error)
    );

endmodule

`default_nettype wire

[design/nonl_chk.sv]
// port-level checker for the likelihood block, bound to the top level
`default_nettype none

module nonl_chk #(
    parameter int FRAC_BITS = 16
) (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic [FRAC_BITS:0] likelihood,
    input wire logic               state_error
);
    localparam logic [FRAC_BITS:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

    // a stalled result stays offered
    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped while stalled");

    // a stalled result keeps its payload
    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(likelihood) && $stable(state_error))
        else $error("result payload changed while stalled");

    // an invalid node state gives a zero likelihood
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && state_error |-> likelihood == '0)
        else $error("state error with non-zero likelihood");

    // likelihood never exceeds one
    a_lik_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> likelihood <= ONE_Q)
        else $error("likelihood above one");

endmodule

bind noisy_or_nor_likelihood nonl_chk #(.FRAC_BITS(FRAC_BITS)) u_nonl_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .likelihood  (result.likelihood),
    .state_error (result.state_error)
);

`default_nettype wire

[tb/testbench.sv]
// self-checking testbench of the noisy or/nor likelihood block
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import nonl_pkg::*;

    localparam int FRAC_BITS = 16;
    localparam int Q_W = FRAC_BITS + 1;
    localparam logic [63:0] Q_ONE = 64'd1 << FRAC_BITS;
    localparam logic [63:0] Q_MASK = (Q_ONE << 1) - 64'd1;
    localparam logic [Q_W-1:0] Q_ONE_F = Q_W'(Q_ONE);
    localparam logic [Q_W-1:0] Q_ALL_F = '1;

    // sign code outside the package list, counted like sign zero in most states
    localparam logic [1:0] SIGN_THREE = 2'd3;

    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_ITEMS = 100;
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_IDLE = 18;

    typedef struct packed {
        logic [Q_W-1:0] act_prob;
        logic           present;
        logic [1:0]     sign;
        logic           last;
    } parent_item_t;

    typedef struct packed {
        logic [Q_W-1:0] likelihood;
        logic           state_error;
    } outcome_t;

    // running products and register copies, expected outcomes in order
    class likelihood_scoreboard;
        logic [63:0] noise_not_one, noise_one;
        logic [63:0] prior_zero, prior_one, prior_two;
        logic [1:0]  node_state;
        logic        data_one;
        logic [63:0] zc_prod, main_prod, two_prod;
        outcome_t    expected_q[$];
        int          errors, parents_seen, results_seen;
        int          per_state[4];

        function new();
            noise_not_one = 0;
            noise_one = 0;
            prior_zero = 0;
            prior_one = 0;
            prior_two = 0;
            node_state = NODE_ZERO;
            data_one = 1'b0;
            errors = 0;
            parents_seen = 0;
            results_seen = 0;
            foreach (per_state[i]) per_state[i] = 0;
            clear_products();
        endfunction

        function void clear_products();
            zc_prod = Q_ONE;
            main_prod = Q_ONE;
            two_prod = Q_ONE;
        endfunction

        // queue an expected outcome at the tail
        function void add_expected(outcome_t res);
            expected_q.insert(expected_q.size(), res);
        endfunction

        // truncating fixed-point product
        function logic [63:0] fix_mul(logic [63:0] a, logic [63:0] b);
            return (a * b) >> FRAC_BITS;
        endfunction

        // anything above one counts as one
        function logic [63:0] clamp_q(logic [63:0] v);
            v = v & Q_MASK;
            return (v > Q_ONE) ? Q_ONE : v;
        endfunction

        function void write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
            logic [63:0] q;
            q = clamp_q(64'(value));
            case (idx)
                REG_NOISE_NOT_ONE: noise_not_one = q;
                REG_NOISE_ONE:     noise_one = q;
                REG_PRIOR_ZERO:    prior_zero = q;
                REG_PRIOR_ONE:     prior_one = q;
                REG_PRIOR_TWO:     prior_two = q;
                REG_NODE_STATE:    node_state = value[1:0];
                REG_DATA_IS_ONE:   data_one = value[0];
                default: ;
            endcase
        endfunction

        // accepted parent: update products, and on the last one the likelihood
        function void note_parent(parent_item_t item);
            logic [63:0] t, z, p, c, lik;
            outcome_t    res;
            parents_seen++;
            t = clamp_q(64'(item.act_prob));
            z = data_one ? noise_one : noise_not_one;
            if (node_state == NODE_BAD)
            begin
                if (!item.last)
                    return;
                clear_products();
                res.likelihood = '0;
                res.state_error = 1'b1;
                add_expected(res);
                per_state[node_state]++;
                return;
            end
            if (item.sign != SIGN_IGNORED)
            begin
                zc_prod = fix_mul(zc_prod, Q_ONE - z);
                if (item.present)
                begin
                    p = fix_mul(Q_ONE - t, z);
                    if (node_state == NODE_ZERO)
                    begin
                        if (item.sign == SIGN_ZERO)
                            main_prod = fix_mul(main_prod, p);
                    end
                    else if (node_state == NODE_ONE || item.sign != SIGN_TWO)
                        main_prod = fix_mul(main_prod, p);
                    else
                        two_prod = fix_mul(two_prod, p);
                end
            end
            if (!item.last)
                return;
            c = Q_ONE - zc_prod;
            case (node_state)
                NODE_ZERO: lik = fix_mul(Q_ONE - main_prod, c) + fix_mul(zc_prod, prior_zero);
                NODE_ONE:  lik = fix_mul(main_prod, c) + fix_mul(zc_prod, prior_one);
                default:   lik = fix_mul(main_prod - fix_mul(two_prod, main_prod), c)
                               + fix_mul(zc_prod, prior_two);
            endcase
            if (lik > Q_ONE)
                lik = Q_ONE;
            clear_products();
            res.likelihood = lik[Q_W-1:0];
            res.state_error = 1'b0;
            add_expected(res);
            per_state[node_state]++;
        endfunction

        task report(string msg);
            $display("%t mismatch: %s", $realtime, msg);
            errors++;
        endtask

        // accepted result against the oldest expectation
        task check_result(logic [Q_W-1:0] likelihood, logic state_error);
            outcome_t want;
            results_seen++;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result %0d (likelihood %h error %b) with nothing expected",
                                 results_seen, likelihood, state_error));
                return;
            end
            want = expected_q.pop_front();
            if (likelihood !== want.likelihood)
                report($sformatf("result %0d likelihood %h, expected %h",
                                 results_seen, likelihood, want.likelihood));
            if (state_error !== want.state_error)
                report($sformatf("result %0d state_error %b, expected %b",
                                 results_seen, state_error, want.state_error));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic        pready;
    logic [31:0] prdata;

    nonl_in_if  #(.FRAC_BITS(FRAC_BITS)) par_ch ();
    nonl_out_if #(.FRAC_BITS(FRAC_BITS)) res_ch ();

    likelihood_scoreboard sb = new();

    bit tx_burst;
    bit rx_burst;
    int settings_seen;

    noisy_or_nor_likelihood #(.FRAC_BITS(FRAC_BITS)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .parent  (par_ch),
        .result  (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .pready  (pready),
        .prdata  (prdata)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // hard limit on the run
    initial
    begin
        #5_000_000;
        $display("timeout with %0d results still expected", sb.expected_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // idle count of either side, zero during a burst
    function automatic int draw_idle(bit burst);
        if (burst)
            return 0;
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(0, MAX_IDLE);
        return $urandom_range(0, 3);
    endfunction

    function automatic logic [Q_W-1:0] pick_q();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return Q_ONE_F;
            2:       return Q_W'($urandom_range(Q_ONE_F + 1, Q_ALL_F));
            default: return Q_W'($urandom_range(0, Q_ONE_F));
        endcase
    endfunction

    // apb write: setup then access, then idle with psel low
    task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.write_reg(idx, value);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic cfg_write_all(input logic [Q_W-1:0] nz0, input logic [Q_W-1:0] nz1,
                                 input logic [Q_W-1:0] pr0, input logic [Q_W-1:0] pr1,
                                 input logic [Q_W-1:0] pr2, input logic [1:0] state,
                                 input logic data_one);
        cfg_write(REG_NOISE_NOT_ONE, 32'(nz0));
        cfg_write(REG_NOISE_ONE, 32'(nz1));
        cfg_write(REG_PRIOR_ZERO, 32'(pr0));
        cfg_write(REG_PRIOR_ONE, 32'(pr1));
        cfg_write(REG_PRIOR_TWO, 32'(pr2));
        cfg_write(REG_NODE_STATE, 32'(state));
        cfg_write(REG_DATA_IS_ONE, 32'(data_one));
        settings_seen++;
    endtask

    // stop offering parents, wait for every expected result, then let the block drain
    task automatic settle();
        par_ch.valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one parent transaction; valid stays high across back-to-back items
    task automatic send_parent(input parent_item_t item);
        int gap;
        gap = draw_idle(tx_burst);
        if (gap > 0)
        begin
            par_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        par_ch.valid <= 1'b1;
        par_ch.parent_act_prob <= item.act_prob;
        par_ch.parent_present <= item.present;
        par_ch.parent_sign <= item.sign;
        par_ch.last_parent <= item.last;
        do @(posedge clk); while (!par_ch.ready);
        sb.note_parent(item);
    endtask

    function automatic parent_item_t random_parent(bit last);
        parent_item_t item;
        int r;
        case ($urandom_range(0, 9))
            0:       item.act_prob = '0;
            1:       item.act_prob = Q_ONE_F;
            2:       item.act_prob = Q_W'($urandom_range(0, Q_ALL_F));
            default: item.act_prob = Q_W'($urandom_range(0, Q_ONE_F));
        endcase
        item.present = ($urandom_range(0, 3) != 0);
        r = $urandom_range(0, 9);
        if (r < 4)
            item.sign = SIGN_ZERO;
        else if (r < 7)
            item.sign = SIGN_TWO;
        else if (r < 9)
            item.sign = SIGN_IGNORED;
        else
            item.sign = SIGN_THREE;
        item.last = last;
        return item;
    endfunction

    // one node: a run of parents closed by a last parent
    task automatic send_node(output int count);
        int len;
        tx_burst = ($urandom_range(0, 4) == 0);
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
            send_parent(random_parent(i == len - 1));
        count = len;
    endtask

    // directed parents: field extremes, every sign, and an ignored-only list
    localparam parent_item_t DIRECTED [6] = '{
        '{17'h00000, 1'b1, SIGN_ZERO,    1'b0},
        '{17'h10000, 1'b1, SIGN_TWO,     1'b0},
        '{17'h1FFFF, 1'b1, SIGN_THREE,   1'b0},
        '{17'h0ABCD, 1'b0, SIGN_ZERO,    1'b0},
        '{17'h12345, 1'b1, SIGN_IGNORED, 1'b1},
        '{17'h08000, 1'b1, SIGN_IGNORED, 1'b1}
    };
    localparam logic [1:0] DIRECTED_STATES [4] = '{NODE_ZERO, NODE_ONE, NODE_TWO, NODE_BAD};

    // result side: random stalls with bursts of constant ready
    initial
    begin
        int stall;
        res_ch.ready <= 1'b0;
        rx_burst = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 7) == 0)
                rx_burst = ~rx_burst;
            stall = draw_idle(rx_burst);
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!res_ch.valid);
            sb.check_result(res_ch.likelihood, res_ch.state_error);
        end
    end

    // stimulus
    initial
    begin
        int sent, n;
        logic [1:0] state;
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        par_ch.valid <= 1'b0;
        par_ch.parent_act_prob <= '0;
        par_ch.parent_present <= 1'b0;
        par_ch.parent_sign <= SIGN_ZERO;
        par_ch.last_parent <= 1'b0;
        tx_burst = 1'b0;
        settings_seen = 1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, first node state with the reset register values
        foreach (DIRECTED_STATES[s])
        begin
            if (s == 1)
            begin
                settle();
                cfg_write_all(17'h03000, 17'h0C000, 17'h04000, 17'h08000, 17'h0FFFF,
                              DIRECTED_STATES[s], 1'b0);
            end
            else if (s > 1)
            begin
                settle();
                cfg_write(REG_NODE_STATE, 32'(DIRECTED_STATES[s]));
                cfg_write(REG_DATA_IS_ONE, 32'(s % 2));
                settings_seen++;
            end
            foreach (DIRECTED[i])
                send_parent(DIRECTED[i]);
        end

        // random phases: extreme settings first, then random ones
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            settle();
            case (ph)
                0: cfg_write_all(Q_ONE_F, Q_ONE_F, Q_ONE_F, Q_ONE_F, Q_ONE_F, NODE_ZERO, 1'b1);
                1: cfg_write_all('0, '0, '0, '0, '0, NODE_ONE, 1'b0);
                2: cfg_write_all(Q_ALL_F, Q_ALL_F, Q_ALL_F, Q_ALL_F, Q_ALL_F, NODE_TWO, 1'b1);
                3: cfg_write_all(pick_q(), pick_q(), pick_q(), pick_q(), pick_q(), NODE_BAD,
                                 1'($urandom_range(0, 1)));
                default:
                begin
                    state = ($urandom_range(0, 7) == 0) ? NODE_BAD : 2'($urandom_range(0, 2));
                    cfg_write_all(pick_q(), pick_q(), pick_q(), pick_q(), pick_q(), state,
                                  1'($urandom_range(0, 1)));
                end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                send_node(n);
                sent += n;
            end
            // sometimes leave a node open across the next register change
            if (ph < RANDOM_PHASES - 1 && $urandom_range(0, 1) == 1)
            begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                    send_parent(random_parent(1'b0));
            end
        end

        // drain
        par_ch.valid <= 1'b0;
        settle();
        if (sb.expected_q.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
        $display("covered %0d parent transactions, %0d result transactions, %0d settings",
                 sb.parents_seen, sb.results_seen, settings_seen);
        $display("results by node state: zero %0d, one %0d, two %0d, invalid %0d; %0d errors",
                 sb.per_state[0], sb.per_state[1], sb.per_state[2], sb.per_state[3], sb.errors);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
